// ===== design/assert_macros.svh =====
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked on the clock after the antecedent
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ugwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ugwd_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        malformed;
      logic        cluster_start;
      logic [1:0]  columns;
      logic        last_of_run;
   } rsp_type;

   // one value handed from the decoder to the clusterer
   typedef struct packed {
      logic [20:0] value;
      logic [2:0]  nbytes;
      logic        bad;
      logic        last;      // final value caused by its byte
      logic        text_end;  // clear cluster state after this value
   } cp_type;

   localparam int unsigned QueueDepth = 4;

   localparam logic [20:0] Zwj         = 21'h200D;
   localparam logic [20:0] RegionalLo  = 21'h1F1E6;
   localparam logic [20:0] RegionalHi  = 21'h1F1FF;
   localparam logic [20:0] Vs15        = 21'hFE0E;
   localparam logic [20:0] Vs16        = 21'hFE0F;
   localparam logic [20:0] ToneLo      = 21'h1F3FB;
   localparam logic [20:0] ToneHi      = 21'h1F3FF;
   localparam logic [20:0] Min4        = 21'h10000;
   localparam logic [20:0] Min3        = 21'h800;
   localparam logic [20:0] IdeoSpace   = 21'h303F;
   localparam logic [20:0] PictLo      = 21'h1F300;
   localparam logic [20:0] SupIdeoLo   = 21'h20000;

   function automatic logic in_rng(input logic [20:0] v, input logic [20:0] lo,
                                   input logic [20:0] hi);
      in_rng = (v >= lo) && (v <= hi);
   endfunction

   function automatic logic is_regional(input logic [20:0] v);
      is_regional = in_rng(v, RegionalLo, RegionalHi);
   endfunction

   function automatic logic is_extender(input logic [20:0] v);
      is_extender = v == Vs15 || v == Vs16 || in_rng(v, ToneLo, ToneHi) || v == Zwj ||
         in_rng(v, 21'h0300, 21'h036F) || in_rng(v, 21'h1AB0, 21'h1AFF) ||
         in_rng(v, 21'h1DC0, 21'h1DFF) || in_rng(v, 21'h20D0, 21'h20FF) ||
         in_rng(v, 21'hFE20, 21'hFE2F);
   endfunction

   function automatic logic [1:0] width_of(input logic [20:0] v);
      logic wide;
      wide = in_rng(v, 21'h1100, 21'h115F) || v == 21'h2329 || v == 21'h232A ||
         in_rng(v, 21'h231A, 21'h231B) || in_rng(v, 21'h23E9, 21'h23F3) ||
         in_rng(v, 21'h23F8, 21'h23FA) || in_rng(v, 21'h25AA, 21'h25AB) ||
         in_rng(v, 21'h25B6, 21'h25C0) || in_rng(v, 21'h25FB, 21'h25FE) ||
         in_rng(v, 21'h2600, 21'h27BF) || in_rng(v, 21'h2934, 21'h2935) ||
         in_rng(v, 21'h2B05, 21'h2B07) || in_rng(v, 21'h2B1B, 21'h2B1C) ||
         v == 21'h2B50 || v == 21'h2B55 ||
         (in_rng(v, 21'h2E80, 21'hA4CF) && v != IdeoSpace) ||
         in_rng(v, 21'hAC00, 21'hD7A3) || in_rng(v, 21'hF900, 21'hFAFF) ||
         in_rng(v, 21'hFE10, 21'hFE1F) || in_rng(v, 21'hFE30, 21'hFE6F) ||
         in_rng(v, 21'hFF00, 21'hFF60) || in_rng(v, 21'hFFE0, 21'hFFE6) ||
         is_regional(v) || in_rng(v, PictLo, 21'h1F64F) ||
         in_rng(v, 21'h1F680, 21'h1F6FF) || in_rng(v, 21'h1F900, 21'h1FAFF) ||
         in_rng(v, SupIdeoLo, 21'h2FFFF);
      if (v < 21'd32 || in_rng(v, 21'h7F, 21'h9F) || is_extender(v)) begin
         width_of = 2'd0;
      end else if (wide) begin
         width_of = 2'd2;
      end else begin
         width_of = 2'd1;
      end
   endfunction

endpackage
`default_nettype wire

// ===== design/ugwd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// byte decoder: takes one byte a transfer, emits up to four values one per cycle while cp_ready is high
module ugwd_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   output logic                     req_full,
   input  wire ugwd_pkg::req_type   req_data,
   output logic                     cp_valid,
   input  wire                      cp_ready,
   output ugwd_pkg::cp_type         cp_data
);
   import ugwd_pkg::*;

   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  tail0_ff, tail0_in, tail1_ff, tail1_in;
   logic [1:0]  held_ff, held_in;

   // pending output run, up to four values
   cp_type      run_ff [4];
   cp_type      run_in [4];
   logic [2:0]  run_n_ff, run_n_in;
   logic [1:0]  run_i_ff, run_i_in;

   logic        accept;
   logic        last_out;
   cp_type      seq [4];
   logic [2:0]  n;
   logic [7:0]  b;
   logic [20:0] v;
   logic [20:0] minv;
   logic [2:0]  need;
   logic [1:0]  h;
   logic        ends;

   assign last_out = cp_valid && cp_ready && (run_i_ff == run_n_ff[1:0] - 2'd1);
   assign req_full = cp_valid && !last_out;
   assign accept   = req_push && !req_full;
   assign cp_valid = run_n_ff != 3'd0;
   assign cp_data  = run_ff[run_i_ff];

   always_comb begin
      lead_in  = lead_ff;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      held_in  = held_ff;
      run_n_in = run_n_ff;
      run_i_in = run_i_ff;
      for (int k = 0; k < 4; k++) begin
         run_in[k] = run_ff[k];
         seq[k]    = '0;
      end
      n    = 3'd0;
      b    = req_data.text_byte;
      h    = held_ff;
      ends = 1'b0;
      need = (lead_ff < 8'hE0) ? 3'd2 : (lead_ff < 8'hF0) ? 3'd3 : 3'd4;
      v    = '0;
      minv = '0;
      if (cp_valid && cp_ready) begin
         if (last_out) begin
            run_n_in = 3'd0;
            run_i_in = 2'd0;
         end else begin
            run_i_in = run_i_ff + 2'd1;
         end
      end
      if (accept) begin
         if (h != 2'd0 && b[7:6] == 2'b10) begin
            if ({1'b0, h} + 3'd1 < need) begin
               if (h == 2'd1) tail0_in = b;
               else tail1_in = b;
               h = h + 2'd1;
            end else begin
               if (need == 3'd2) begin
                  v = {10'd0, lead_ff[4:0], b[5:0]};
                  minv = 21'h80;
               end else if (need == 3'd3) begin
                  v = {5'd0, lead_ff[3:0], tail0_ff[5:0], b[5:0]};
                  minv = Min3;
               end else begin
                  v = {lead_ff[2:0], tail0_ff[5:0], tail1_ff[5:0], b[5:0]};
                  minv = Min4;
               end
               if (v >= minv) begin
                  seq[0] = '{v, need, 1'b0, 1'b0, 1'b0};
                  n = 3'd1;
               end else begin
                  seq[0] = '{{13'd0, lead_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
                  seq[1] = '{{13'd0, tail0_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
                  seq[2] = '{{13'd0, tail1_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
                  seq[need[1:0] - 2'd1] = '{{13'd0, b}, 3'd1, 1'b1, 1'b0, 1'b0};
                  n = need;
               end
               h = 2'd0;
            end
         end else begin
            // flush held bytes, then decode the byte afresh
            if (h != 2'd0) begin
               seq[0] = '{{13'd0, lead_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
               seq[1] = '{{13'd0, tail0_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
               seq[2] = '{{13'd0, tail1_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
               n = {1'b0, h};
               h = 2'd0;
            end
            if (b < 8'h80) begin
               seq[n[1:0]] = '{{13'd0, b}, 3'd1, 1'b0, 1'b0, 1'b0};
               n = n + 3'd1;
            end else if (b < 8'hC0 || b >= 8'hF8) begin
               seq[n[1:0]] = '{{13'd0, b}, 3'd1, 1'b1, 1'b0, 1'b0};
               n = n + 3'd1;
            end else begin
               lead_in = b;
               h = 2'd1;
            end
         end
         if (req_data.text_end) begin
            if (h != 2'd0) begin
               // a single held byte is the new lead, after anything flushed
               if (h == 2'd1) begin
                  seq[n[1:0]] = '{{13'd0, lead_in}, 3'd1, 1'b1, 1'b0, 1'b0};
                  n = n + 3'd1;
               end else begin
                  seq[0] = '{{13'd0, lead_ff}, 3'd1, 1'b1, 1'b0, 1'b0};
                  seq[1] = '{{13'd0, (h == 2'd2) ? tail0_in : tail0_ff}, 3'd1, 1'b1,
                             1'b0, 1'b0};
                  seq[2] = '{{13'd0, tail1_in}, 3'd1, 1'b1, 1'b0, 1'b0};
                  n = {1'b0, h};
               end
               h = 2'd0;
            end
            ends = 1'b1;
         end
         held_in = h;
         if (n != 3'd0) begin
            seq[n[1:0] - 2'd1].last = 1'b1;
            seq[n[1:0] - 2'd1].text_end = ends;
            for (int k = 0; k < 4; k++) run_in[k] = seq[k];
            run_n_in = n;
            run_i_in = 2'd0;
         end else if (ends) begin
            // no value: pass a clear marker with zero bytes
            run_in[0] = '{21'd0, 3'd0, 1'b0, 1'b0, 1'b1};
            run_n_in = 3'd1;
            run_i_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 2'd0;
         run_n_ff <= 3'd0;
         run_i_ff <= 2'd0;
         lead_ff  <= 8'd0;
         tail0_ff <= 8'd0;
         tail1_ff <= 8'd0;
      end else begin
         held_ff  <= held_in;
         run_n_ff <= run_n_in;
         run_i_ff <= run_i_in;
         lead_ff  <= lead_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
      end
      for (int k = 0; k < 4; k++) run_ff[k] <= run_in[k];
   end
endmodule
`default_nettype wire

// ===== design/ugwd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// short queue between decoder and clusterer
module ugwd_queue #(
   parameter int unsigned Depth = ugwd_pkg::QueueDepth
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  wire ugwd_pkg::cp_type  in_data,
   output logic                   out_valid,
   input  wire                    out_ready,
   output ugwd_pkg::cp_type       out_data
);
   import ugwd_pkg::*;
   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

   cp_type          mem_ff [Depth];
   logic [Aw-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [Aw:0]     cnt_ff, cnt_in;
   logic            wr, rd;

   assign in_ready  = cnt_ff != (Aw+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_comb begin
      wr_in  = wr ? ((wr_ff == Aw'(Depth - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = rd ? ((rd_ff == Aw'(Depth - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (Aw+1)'(wr) - (Aw+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (wr) mem_ff[wr_ff] <= in_data;
   end
endmodule
`default_nettype wire

// ===== design/ugwd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// clusterer: tags each value with cluster start and width, registered output
module ugwd_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      cp_valid,
   output logic                     cp_ready,
   input  wire ugwd_pkg::cp_type    cp_data,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output ugwd_pkg::rsp_type        rsp_data
);
   import ugwd_pkg::*;

   logic     begun_ff, begun_in, join_ff, join_in, flag_ff, flag_in;
   logic     full_ff, full_in;
   rsp_type  out_ff, out_in;
   logic     take, marker, start;
   logic [20:0] v;

   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;
   assign cp_ready  = !full_ff || rsp_pop;
   assign take      = cp_valid && cp_ready;
   assign marker    = cp_data.nbytes == 3'd0;
   assign v         = cp_data.value;

   always_comb begin
      begun_in = begun_ff;
      join_in  = join_ff;
      flag_in  = flag_ff;
      full_in  = full_ff && !rsp_pop;
      out_in   = out_ff;
      start    = 1'b1;
      if (take) begin
         if (!marker) begin
            if (!begun_ff) begin
               start = 1'b1;
            end else if (join_ff) begin
               start = 1'b0;
               join_in = 1'b0;
            end else if (is_extender(v)) begin
               start = 1'b0;
               join_in = v == Zwj;
            end else if (flag_ff && is_regional(v)) begin
               start = 1'b0;
               flag_in = 1'b0;
            end
            if (start) begin
               join_in = 1'b0;
               flag_in = is_regional(v);
            end
            begun_in = 1'b1;
            out_in = '{v, cp_data.nbytes, cp_data.bad, start,
                       start ? width_of(v) : 2'd0, cp_data.last};
            full_in = 1'b1;
         end
         if (cp_data.text_end) begin
            begun_in = 1'b0;
            join_in  = 1'b0;
            flag_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         begun_ff <= 1'b0;
         join_ff  <= 1'b0;
         flag_ff  <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         begun_ff <= begun_in;
         join_ff  <= join_in;
         flag_ff  <= flag_in;
         full_ff  <= full_in;
      end
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

// ===== design/utf8_grapheme_width_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 decoder with grapheme clustering and display width. Takes one text
// byte per transfer on the req_ queue side and gives one result per transfer
// on the rsp_ side. A byte that completes a code point or passes through
// malformed yields one result; a byte that flushes a broken sequence yields up
// to four results, and the decoder hands them on one at a time, which holds
// req_full high until the last of them is taken. Bytes that only extend a
// sequence give no result. A four-entry queue parts decoder and clusterer.
module utf8_grapheme_width_decoder #(
   parameter int unsigned QueueDepth = ugwd_pkg::QueueDepth
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   output logic                     req_full,
   input  wire ugwd_pkg::req_type   req_data,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output ugwd_pkg::rsp_type        rsp_data
);
   import ugwd_pkg::*;

   logic   f_valid, f_ready, b_valid, b_ready;
   cp_type f_data, b_data;

   ugwd_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cp_valid(f_valid), .cp_ready(f_ready), .cp_data(f_data)
   );

   ugwd_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   ugwd_back u_back (
      .clock, .reset,
      .cp_valid(b_valid), .cp_ready(b_ready), .cp_data(b_data),
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule
`default_nettype wire

// ===== design/ugwd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ugwd_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_push,
   input wire                     req_full,
   input wire                     rsp_empty,
   input wire                     rsp_pop,
   input wire ugwd_pkg::rsp_type  rsp_data
);
   import ugwd_pkg::*;

   `CHECK_IMPLY(a_count, clock, reset, !rsp_empty, rsp_data.byte_count >= 3'd1 && rsp_data.byte_count <= 3'd4, "bad byte count")
   `CHECK_IMPLY(a_bad_one, clock, reset, !rsp_empty && rsp_data.malformed, rsp_data.byte_count == 3'd1 && rsp_data.code_point < 21'd256, "malformed not single byte")
   `CHECK_IMPLY(a_cols, clock, reset, !rsp_empty && !rsp_data.cluster_start, rsp_data.columns == 2'd0, "columns off cluster start")
   `CHECK_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "result changed while waiting")
endmodule

bind utf8_grapheme_width_decoder ugwd_checker u_checker (.*);
`default_nettype wire
